// ===== rtl/ptrc_pkg.sv =====
// Package for the pose transform and residual cost core.
// Holds widths, constants, the arctangent table and shared types.
// No dependencies.
package ptrc_pkg;

  localparam int POS_BITS        = 32;
  localparam int ANGLE_BITS      = 16;
  localparam int TRIG_ITERATIONS = 16;
  localparam int ITER_W          = 5;
  localparam int TRIG_W          = 33;
  localparam int CORD_W          = 34;
  localparam int MUL_W           = 33;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int ACC_W           = 36;
  localparam int COST_W          = 63;
  localparam int WEIGHT_W        = 32;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int IN_DATA_W       = 192;
  localparam int OUT_DATA_W      = 224;

  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [MUL_W-1:0]  YAW_W_HI    = 33'sd25872;
  localparam logic signed [MUL_W-1:0]  YAW_W_LO    = 33'sd37733;
  localparam logic [COST_W-1:0]        COST_MAX    = {COST_W{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORIGIN_X  = 3'd0,
    REG_ORIGIN_Y  = 3'd1,
    REG_MAP_ROT   = 3'd2,
    REG_HEAD_OFF  = 3'd3,
    REG_LEVER_FWD = 3'd4,
    REG_LEVER_LAT = 3'd5,
    REG_OFF_EN    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_res_t;

  function automatic logic signed [31:0] atan_entry(input logic [ITER_W-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sh20000000;
      5'd1:  v = 32'sh12E4051E;
      5'd2:  v = 32'sh09FB385B;
      5'd3:  v = 32'sh051111D4;
      5'd4:  v = 32'sh028B0D43;
      5'd5:  v = 32'sh0145D7E1;
      5'd6:  v = 32'sh00A2F61E;
      5'd7:  v = 32'sh00517C55;
      5'd8:  v = 32'sh0028BE53;
      5'd9:  v = 32'sh00145F2F;
      5'd10: v = 32'sh000A2F98;
      5'd11: v = 32'sh000517CC;
      5'd12: v = 32'sh00028BE6;
      5'd13: v = 32'sh000145F3;
      5'd14: v = 32'sh0000A2FA;
      5'd15: v = 32'sh0000517D;
      5'd16: v = 32'sh000028BE;
      5'd17: v = 32'sh0000145F;
      5'd18: v = 32'sh00000A30;
      5'd19: v = 32'sh00000518;
      5'd20: v = 32'sh0000028C;
      5'd21: v = 32'sh00000146;
      5'd22: v = 32'sh000000A3;
      5'd23: v = 32'sh00000051;
      default: v = 32'sh00000000;
    endcase
    return v;
  endfunction

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    logic signed [POS_BITS-1:0] r;
    hi = ACC_W'({1'b0, {(POS_BITS-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (v > hi) begin
      r = {1'b0, {(POS_BITS-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, {(POS_BITS-1){1'b0}}};
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ptrc_cordic.sv =====
// Iterative CORDIC sine and cosine of a binary angle, one rotation step per cycle.
// Depends on ptrc_pkg.
module ptrc_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [ptrc_pkg::ANGLE_BITS-1:0]     angle,
  output ptrc_pkg::trig_res_t                 res
);

  logic signed [ptrc_pkg::CORD_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [31:0]                 z_r, z_nxt;
  logic [1:0]                         quad_r, quad_nxt;
  logic [ptrc_pkg::ITER_W-1:0]        iter_r, iter_nxt;
  logic                               run_r, run_nxt;
  logic                               done_r, done_nxt;
  logic signed [ptrc_pkg::TRIG_W-1:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic [31:0]                        shifted;
  logic signed [ptrc_pkg::CORD_W-1:0] dx, dy;
  logic signed [31:0]                 atan_v;

  assign shifted = {angle, {(32-ptrc_pkg::ANGLE_BITS){1'b0}}} + 32'h2000_0000;
  assign dx      = y_r >>> iter_r;
  assign dy      = x_r >>> iter_r;
  assign atan_v  = ptrc_pkg::atan_entry(iter_r);

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    quad_nxt = quad_r;
    iter_nxt = iter_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cos_nxt  = cos_r;
    sin_nxt  = sin_r;
    if (start) begin
      x_nxt    = ptrc_pkg::CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = $signed({2'b00, shifted[29:0]}) - 32'sh2000_0000;
      quad_nxt = shifted[31:30];
      iter_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (iter_r == ptrc_pkg::ITER_W'(ptrc_pkg::TRIG_ITERATIONS)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        case (quad_r)
          2'd0: begin
            cos_nxt = ptrc_pkg::TRIG_W'(x_r);
            sin_nxt = ptrc_pkg::TRIG_W'(y_r);
          end
          2'd1: begin
            cos_nxt = ptrc_pkg::TRIG_W'(-y_r);
            sin_nxt = ptrc_pkg::TRIG_W'(x_r);
          end
          2'd2: begin
            cos_nxt = ptrc_pkg::TRIG_W'(-x_r);
            sin_nxt = ptrc_pkg::TRIG_W'(-y_r);
          end
          default: begin
            cos_nxt = ptrc_pkg::TRIG_W'(y_r);
            sin_nxt = ptrc_pkg::TRIG_W'(-x_r);
          end
        endcase
      end else begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_v;
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_v;
        end
        iter_nxt = iter_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    quad_r <= quad_nxt;
    cos_r  <= cos_nxt;
    sin_r  <= sin_nxt;
    if (!rst_n) begin
      iter_r <= '0;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      iter_r <= iter_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.cos_v = cos_r;
  assign res.sin_v = sin_r;

endmodule

// ===== rtl/pose_transform_residual_cost_core.sv =====
// Top level of the pose transform and residual cost core.
// Depends on ptrc_pkg and ptrc_cordic.
//
// Each input item is a tracker pose, a reference pose and a weight; one result item comes
// back per input item. Each item takes two CORDIC runs (one when the lever-arm offset is
// off), fifteen products on a single shared 33x33 multiplier (eleven when the offset is
// off), a saturation and error step and the load of the output register. The input is
// not ready while an item is at work; a finished result waits in the output register while
// the next item is taken, and a result that cannot be loaded because the previous one is
// still waiting holds the block for as long as the output stalls.
module pose_transform_residual_cost_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [ptrc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [ptrc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // track_x, track_y, track_yaw, ref_x, ref_y, ref_yaw, pair_weight (lowest bit first)
  input  logic [ptrc_pkg::IN_DATA_W-1:0]       in_tdata,
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pred_x, pred_y, pred_yaw, err_x, err_y, err_yaw, running_cost, one zero pad bit
  output logic [ptrc_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast
);

  localparam int PW = ptrc_pkg::POS_BITS;
  localparam int AW = ptrc_pkg::ANGLE_BITS;
  localparam int MW = ptrc_pkg::MUL_W;
  localparam int XW = ptrc_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ROT, S_MUL, S_ACC, S_HEAD, S_ERR, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_TX_CR, OP_TY_SR, OP_TX_SR, OP_TY_CR, OP_FWD_CH, OP_LAT_SH, OP_FWD_SH, OP_LAT_CH,
    OP_AX_AX, OP_AY_AY, OP_AE_AE, OP_E2_HI, OP_E2_LO, OP_W_QH, OP_W_QL
  } op_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  logic signed [PW-1:0] ox_r, oy_r, fwd_r, lat_r;
  logic [AW-1:0]        rot_r, hoff_r;
  logic                 en_r;

  logic signed [PW-1:0] tx_r, tx_nxt, ty_r, ty_nxt, rx_r, rx_nxt, ry_r, ry_nxt;
  logic [AW-1:0]        ryaw_r, ryaw_nxt, head_r, head_nxt;
  logic [ptrc_pkg::WEIGHT_W-1:0] w_r, w_nxt;
  logic                 last_r, last_nxt;

  logic signed [ptrc_pkg::TRIG_W-1:0] cr_r, cr_nxt, sr_r, sr_nxt, ch_r, ch_nxt, sh_r, sh_nxt;
  logic signed [XW-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic signed [ptrc_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PW-1:0]  pxs_r, pxs_nxt, pys_r, pys_nxt, ex_r, ex_nxt, ey_r, ey_nxt;
  logic [AW-1:0]         eyaw_r, eyaw_nxt;
  logic [63:0]           q_r, q_nxt, th_r, th_nxt;
  logic [30:0]           e2_r, e2_nxt;
  logic [45:0]           yacc_r, yacc_nxt;
  logic [ptrc_pkg::COST_W-1:0] term_r, term_nxt, cost_r, cost_nxt;

  logic                  out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [ptrc_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  trig_start;
  logic [AW-1:0]         trig_angle;
  ptrc_pkg::trig_res_t   trig;

  logic signed [MW-1:0]  mul_a, mul_b;
  logic signed [ptrc_pkg::PROD_W-1:0] rnd_sum;
  logic signed [XW-1:0]  rnd;
  logic [PW-1:0]         ax, ay;
  logic [AW-1:0]         ae;
  logic [64:0]           hsum;
  logic [63:0]           csum;
  logic [45:0]           ysum;
  logic [AW-1:0]         in_head;

  ptrc_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (trig_start),
    .angle (trig_angle),
    .res   (trig)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  assign rnd_sum = prod_r + ptrc_pkg::PROD_W'(1 << 29);
  assign rnd     = rnd_sum[ptrc_pkg::PROD_W-1:30];
  assign ax      = ex_r[PW-1] ? PW'(-ex_r) : ex_r;
  assign ay      = ey_r[PW-1] ? PW'(-ey_r) : ey_r;
  assign ae      = eyaw_r[AW-1] ? AW'(-eyaw_r) : eyaw_r;
  assign ysum    = yacc_r + 46'(prod_r[63:16]);
  assign hsum    = {1'b0, th_r} + {33'd0, prod_r[63:32]};
  assign csum    = {1'b0, cost_r} + {1'b0, term_r};
  assign in_head = rot_r - in_tdata[79:64] + hoff_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      OP_TX_CR:  begin mul_a = MW'(tx_r);  mul_b = cr_r; end
      OP_TY_SR:  begin mul_a = MW'(ty_r);  mul_b = sr_r; end
      OP_TX_SR:  begin mul_a = MW'(tx_r);  mul_b = sr_r; end
      OP_TY_CR:  begin mul_a = MW'(ty_r);  mul_b = cr_r; end
      OP_FWD_CH: begin mul_a = MW'(fwd_r); mul_b = ch_r; end
      OP_LAT_SH: begin mul_a = MW'(lat_r); mul_b = sh_r; end
      OP_FWD_SH: begin mul_a = MW'(fwd_r); mul_b = sh_r; end
      OP_LAT_CH: begin mul_a = MW'(lat_r); mul_b = ch_r; end
      OP_AX_AX:  begin mul_a = $signed({1'b0, ax}); mul_b = $signed({1'b0, ax}); end
      OP_AY_AY:  begin mul_a = $signed({1'b0, ay}); mul_b = $signed({1'b0, ay}); end
      OP_AE_AE:  begin
        mul_a = $signed({{(MW-AW){1'b0}}, ae});
        mul_b = $signed({{(MW-AW){1'b0}}, ae});
      end
      OP_E2_HI:  begin mul_a = $signed({2'b00, e2_r}); mul_b = ptrc_pkg::YAW_W_HI; end
      OP_E2_LO:  begin mul_a = $signed({2'b00, e2_r}); mul_b = ptrc_pkg::YAW_W_LO; end
      OP_W_QH:   begin mul_a = $signed({1'b0, w_r}); mul_b = $signed({1'b0, q_r[63:32]}); end
      OP_W_QL:   begin mul_a = $signed({1'b0, w_r}); mul_b = $signed({1'b0, q_r[31:0]}); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    tx_nxt = tx_r; ty_nxt = ty_r; rx_nxt = rx_r; ry_nxt = ry_r;
    ryaw_nxt = ryaw_r; head_nxt = head_r; w_nxt = w_r; last_nxt = last_r;
    cr_nxt = cr_r; sr_nxt = sr_r; ch_nxt = ch_r; sh_nxt = sh_r;
    px_nxt = px_r; py_nxt = py_r; prod_nxt = prod_r;
    pxs_nxt = pxs_r; pys_nxt = pys_r; ex_nxt = ex_r; ey_nxt = ey_r; eyaw_nxt = eyaw_r;
    q_nxt = q_r; th_nxt = th_r; e2_nxt = e2_r; yacc_nxt = yacc_r;
    term_nxt = term_r; cost_nxt = cost_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;
    trig_start    = 1'b0;
    trig_angle    = rot_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tx_nxt     = in_tdata[31:0];
          ty_nxt     = in_tdata[63:32];
          rx_nxt     = in_tdata[111:80];
          ry_nxt     = in_tdata[143:112];
          ryaw_nxt   = in_tdata[159:144];
          w_nxt      = in_tdata[191:160];
          last_nxt   = in_tlast;
          head_nxt   = in_head;
          px_nxt     = XW'(ox_r);
          py_nxt     = XW'(oy_r);
          trig_start = 1'b1;
          state_nxt  = S_ROT;
        end
      end
      S_ROT: begin
        if (trig.done) begin
          cr_nxt    = trig.cos_v;
          sr_nxt    = trig.sin_v;
          op_nxt    = OP_TX_CR;
          state_nxt = S_MUL;
        end
      end
      S_HEAD: begin
        if (trig.done) begin
          ch_nxt    = trig.cos_v;
          sh_nxt    = trig.sin_v;
          op_nxt    = OP_FWD_CH;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        op_nxt    = op_t'(op_r + 1'b1);
        state_nxt = S_MUL;
        case (op_r)
          OP_TX_CR:  px_nxt = px_r + rnd;
          OP_TY_SR:  px_nxt = px_r - rnd;
          OP_TX_SR:  py_nxt = py_r + rnd;
          OP_TY_CR:  begin
            py_nxt = py_r + rnd;
            if (en_r) begin
              trig_start = 1'b1;
              trig_angle = head_r;
              state_nxt  = S_HEAD;
            end else begin
              state_nxt = S_ERR;
            end
          end
          OP_FWD_CH: px_nxt = px_r - rnd;
          OP_LAT_SH: px_nxt = px_r + rnd;
          OP_FWD_SH: py_nxt = py_r - rnd;
          OP_LAT_CH: begin
            py_nxt    = py_r - rnd;
            state_nxt = S_ERR;
          end
          OP_AX_AX:  q_nxt = prod_r[63:0];
          OP_AY_AY:  q_nxt = q_r + prod_r[63:0];
          OP_AE_AE:  e2_nxt = prod_r[30:0];
          OP_E2_HI:  yacc_nxt = prod_r[45:0];
          OP_E2_LO:  q_nxt = q_r + 64'(ysum[45:16]);
          OP_W_QH:   th_nxt = prod_r[63:0];
          OP_W_QL:   begin
            term_nxt  = (hsum[64:63] != 2'b00) ? ptrc_pkg::COST_MAX : hsum[62:0];
            state_nxt = S_FIN;
          end
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_ERR: begin
        pxs_nxt   = ptrc_pkg::sat_pos(px_r);
        pys_nxt   = ptrc_pkg::sat_pos(py_r);
        ex_nxt    = ptrc_pkg::sat_pos(XW'(ptrc_pkg::sat_pos(px_r)) - XW'(rx_r));
        ey_nxt    = ptrc_pkg::sat_pos(XW'(ptrc_pkg::sat_pos(py_r)) - XW'(ry_r));
        eyaw_nxt  = head_r - ryaw_r;
        op_nxt    = OP_AX_AX;
        state_nxt = S_MUL;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cost_nxt      = csum[63] ? ptrc_pkg::COST_MAX : csum[62:0];
          out_valid_nxt = 1'b1;
          out_last_nxt  = last_r;
          out_data_nxt  = {1'b0, cost_nxt, eyaw_r, ey_r, ex_r, head_r, pys_r, pxs_r};
          if (last_r) begin
            cost_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    tx_r <= tx_nxt; ty_r <= ty_nxt; rx_r <= rx_nxt; ry_r <= ry_nxt;
    ryaw_r <= ryaw_nxt; head_r <= head_nxt; w_r <= w_nxt; last_r <= last_nxt;
    cr_r <= cr_nxt; sr_r <= sr_nxt; ch_r <= ch_nxt; sh_r <= sh_nxt;
    px_r <= px_nxt; py_r <= py_nxt; prod_r <= prod_nxt;
    pxs_r <= pxs_nxt; pys_r <= pys_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt; eyaw_r <= eyaw_nxt;
    q_r <= q_nxt; th_r <= th_nxt; e2_r <= e2_nxt; yacc_r <= yacc_nxt; term_r <= term_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_TX_CR;
      out_valid_r <= 1'b0;
      cost_r      <= '0;
      ox_r <= '0; oy_r <= '0; rot_r <= '0; hoff_r <= '0;
      fwd_r <= '0; lat_r <= '0; en_r <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
      cost_r      <= cost_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          ptrc_pkg::REG_ORIGIN_X:  ox_r   <= cfg_wdata[PW-1:0];
          ptrc_pkg::REG_ORIGIN_Y:  oy_r   <= cfg_wdata[PW-1:0];
          ptrc_pkg::REG_MAP_ROT:   rot_r  <= cfg_wdata[AW-1:0];
          ptrc_pkg::REG_HEAD_OFF:  hoff_r <= cfg_wdata[AW-1:0];
          ptrc_pkg::REG_LEVER_FWD: fwd_r  <= cfg_wdata[PW-1:0];
          ptrc_pkg::REG_LEVER_LAT: lat_r  <= cfg_wdata[PW-1:0];
          ptrc_pkg::REG_OFF_EN:    en_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/ptrc_checker.sv =====
// Port-level checks for the pose transform and residual cost core.
// Depends on ptrc_pkg; bound to pose_transform_residual_cost_core.
module ptrc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             cfg_we,
  input logic [ptrc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input logic [ptrc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [ptrc_pkg::IN_DATA_W-1:0]   in_tdata,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ptrc_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);

  // A result item is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result item dropped or changed while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again while an item is at work");

  // No result item comes out of reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result item present after reset");

  // The pad bit above the cost field stays clear.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[ptrc_pkg::OUT_DATA_W-1])
    else $error("pad bit of result item set");

endmodule

bind pose_transform_residual_cost_core ptrc_checker u_ptrc_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for pose_transform_residual_cost_core.
// Predicts each result item from its own fixed-point model and compares it field by field.
// Depends on ptrc_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [31:0] weight;
    logic [15:0] ryaw;
    logic [31:0] ry;
    logic [31:0] rx;
    logic [15:0] tyaw;
    logic [31:0] ty;
    logic [31:0] tx;
  } pose_pair_t;

  typedef struct {
    pose_pair_t data;
    logic       last;
  } pair_item_t;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] pyaw;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [15:0] eyaw;
    logic [62:0] cost;
    logic        last;
  } residual_t;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ptrc_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [ptrc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ptrc_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [ptrc_pkg::OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;

  pose_transform_residual_cost_core u_top (.*);

  always #6 clk = ~clk;

  pair_item_t pending_pairs[$];
  residual_t  expected_residuals[$];
  int errors = 0;
  int hold_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit done_sending = 1'b0;
  longint cycles = 0;

  longint org_x, org_y, rot, hoff, lev_f, lev_l;
  bit lever_on;
  logic [63:0] cost_acc;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic longint wrap16(longint v);
    logic [15:0] b;
    b = v[15:0];
    return longint'($signed(b));
  endfunction

  function automatic longint trig_product(longint p, longint c);
    longint hi, lo, a, ah, al, rest;
    hi = floor_shift(p, 16);
    lo = p - hi * 65536;
    a = hi * c;
    ah = floor_shift(a, 14);
    al = a - ah * 16384;
    rest = al * 65536 + lo * c + (64'sd1 <<< 29);
    return ah + floor_shift(rest, 30);
  endfunction

  function automatic void cordic(longint ang, output longint co, output longint si);
    logic [31:0] a, sh;
    logic [1:0] quad;
    longint x, y, z, dx, dy;
    longint atans[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                          32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                          32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                          32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
    a = {ang[15:0], 16'h0};
    sh = a + 32'h20000000;
    quad = sh[31:30];
    z = longint'({2'b00, sh[29:0]}) - 64'sh20000000;
    x = 652032874;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atans[i];
      end else begin
        x += dx; y -= dy; z += atans[i];
      end
    end
    case (quad)
      2'd0: begin co = x; si = y; end
      2'd1: begin co = -y; si = x; end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  function automatic logic [63:0] add_sat64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic residual_t predict_residual(pair_item_t it);
    residual_t r;
    longint tx, ty, rx, ry, head, cr, sr, ch, sh, px, py, ex, ey, ey2;
    logic [63:0] ax, ay, ae, e2, yq, q, term;
    logic [127:0] wide;
    tx = longint'($signed(it.data.tx));
    ty = longint'($signed(it.data.ty));
    rx = longint'($signed(it.data.rx));
    ry = longint'($signed(it.data.ry));
    head = wrap16(-longint'($signed(it.data.tyaw)) + rot + hoff);
    cordic(rot, cr, sr);
    px = trig_product(tx, cr) - trig_product(ty, sr) + org_x;
    py = trig_product(tx, sr) + trig_product(ty, cr) + org_y;
    if (lever_on) begin
      cordic(head, ch, sh);
      px -= trig_product(lev_f, ch) - trig_product(lev_l, sh);
      py -= trig_product(lev_f, sh) + trig_product(lev_l, ch);
    end
    px = clamp_pos(px);
    py = clamp_pos(py);
    ex = clamp_pos(px - rx);
    ey = clamp_pos(py - ry);
    ey2 = wrap16(head - longint'($signed(it.data.ryaw)));
    ax = ex < 0 ? -ex : ex;
    ay = ey < 0 ? -ey : ey;
    ae = ey2 < 0 ? -ey2 : ey2;
    e2 = ae * ae;
    yq = (e2 * 64'd25872 + ((e2 * 64'd37733) >> 16)) >> 16;
    q = add_sat64(add_sat64(ax * ax, ay * ay), yq);
    wide = (128'(it.data.weight) * 128'(q)) >> 32;
    term = wide[127:64] != 0 ? '1 : wide[63:0];
    if (term > 64'h7FFFFFFFFFFFFFFF) term = 64'h7FFFFFFFFFFFFFFF;
    cost_acc = (cost_acc > 64'h7FFFFFFFFFFFFFFF - term) ? 64'h7FFFFFFFFFFFFFFF
                                                        : cost_acc + term;
    r.px = px[31:0];
    r.py = py[31:0];
    r.pyaw = head[15:0];
    r.ex = ex[31:0];
    r.ey = ey[31:0];
    r.eyaw = ey2[15:0];
    r.cost = cost_acc[62:0];
    r.last = it.last;
    if (it.last) cost_acc = 0;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Sender: offers queued items, with random gaps between them.
  always @(posedge clk) begin
    pair_item_t cur;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        cur = pending_pairs.pop_front();
        expected_residuals.insert(expected_residuals.size(), predict_residual(cur));
        send_gap = pick_gap();
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_pairs[0].data;
          in_tlast <= pending_pairs[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result item against the oldest expectation.
  always @(posedge clk) begin
    residual_t e, a;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        a.px = out_tdata[31:0];
        a.py = out_tdata[63:32];
        a.pyaw = out_tdata[79:64];
        a.ex = out_tdata[111:80];
        a.ey = out_tdata[143:112];
        a.eyaw = out_tdata[159:144];
        a.cost = out_tdata[222:160];
        a.last = out_tlast;
        if (expected_residuals.size() == 0) begin
          $error("unexpected result item");
          errors++;
        end else begin
          e = expected_residuals.pop_front();
          if (a.px !== e.px) begin
            $error("pred_x exp %h got %h", e.px, a.px); errors++;
          end
          if (a.py !== e.py) begin
            $error("pred_y exp %h got %h", e.py, a.py); errors++;
          end
          if (a.pyaw !== e.pyaw) begin
            $error("pred_yaw exp %h got %h", e.pyaw, a.pyaw); errors++;
          end
          if (a.ex !== e.ex) begin
            $error("err_x exp %h got %h", e.ex, a.ex); errors++;
          end
          if (a.ey !== e.ey) begin
            $error("err_y exp %h got %h", e.ey, a.ey); errors++;
          end
          if (a.eyaw !== e.eyaw) begin
            $error("err_yaw exp %h got %h", e.eyaw, a.eyaw); errors++;
          end
          if (a.cost !== e.cost) begin
            $error("running_cost exp %h got %h", e.cost, a.cost); errors++;
          end
          if (a.last !== e.last) begin
            $error("last_out exp %b got %b", e.last, a.last); errors++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!done_sending) recv_gap = pick_gap();
      end
    end
  end

  task automatic write_reg(ptrc_pkg::cfg_reg_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ptrc_pkg::REG_ORIGIN_X: org_x = longint'($signed(v));
      ptrc_pkg::REG_ORIGIN_Y: org_y = longint'($signed(v));
      ptrc_pkg::REG_MAP_ROT: rot = longint'($signed(v[15:0]));
      ptrc_pkg::REG_HEAD_OFF: hoff = longint'($signed(v[15:0]));
      ptrc_pkg::REG_LEVER_FWD: lev_f = longint'($signed(v));
      ptrc_pkg::REG_LEVER_LAT: lev_l = longint'($signed(v));
      default: lever_on = v[0];
    endcase
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0);
    wait (!in_tvalid && expected_residuals.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 5))
      0: return 32'h80000000 | $urandom_range(0, 3);
      1: return 32'h7FFFFFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_pair(logic [31:0] tx, logic [31:0] ty, logic [15:0] tyaw,
                            logic [31:0] rx, logic [31:0] ry, logic [15:0] ryaw,
                            logic [31:0] w, logic last);
    pair_item_t it;
    it.data = '{weight: w, ryaw: ryaw, ry: ry, rx: rx, tyaw: tyaw, ty: ty, tx: tx};
    it.last = last;
    pending_pairs.insert(pending_pairs.size(), it);
  endtask

  task automatic queue_random(int n);
    logic [31:0] w;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: w = 32'hFFFFFFFF;
        1: w = $urandom_range(0, 32'h20000);
        default: w = $urandom;
      endcase
      queue_pair(rand_pos(), rand_pos(), 16'($urandom), rand_pos(), rand_pos(),
                 16'($urandom), w, $urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    org_x = 0; org_y = 0; rot = 0; hoff = 0; lev_f = 0; lev_l = 0;
    lever_on = 1'b1;
    cost_acc = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    queue_pair('0, '0, '0, '0, '0, '0, 32'h10000, 1'b0);
    queue_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 16'h8000, 32'h80000000, 32'h80000000,
               16'h7FFF, 32'hFFFFFFFF, 1'b0);
    queue_pair(32'h80000000, 32'h80000000, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               16'h8000, 32'hFFFFFFFF, 1'b0);
    queue_pair(32'h00010000, 32'hFFFF0000, 16'h4000, '0, '0, 16'h8000, '0, 1'b1);
    drain();

    write_reg(ptrc_pkg::REG_ORIGIN_X, 32'h7FFFFFFF);
    write_reg(ptrc_pkg::REG_ORIGIN_Y, 32'h80000000);
    write_reg(ptrc_pkg::REG_MAP_ROT, 32'h00008000);
    write_reg(ptrc_pkg::REG_HEAD_OFF, 32'h00007FFF);
    write_reg(ptrc_pkg::REG_LEVER_FWD, 32'h80000000);
    write_reg(ptrc_pkg::REG_LEVER_LAT, 32'h7FFFFFFF);
    queue_pair(32'h7FFFFFFF, '0, 16'h8000, '0, 32'h7FFFFFFF, 16'h0000, 32'hFFFFFFFF, 1'b0);
    queue_pair('0, 32'h80000000, 16'h0001, 32'h80000000, '0, 16'h8001, 32'h00000001, 1'b0);
    queue_random(6);
    queue_pair(32'h12345678, 32'h9ABCDEF0, 16'h2000, '0, '0, 16'hE000, 32'hFFFF, 1'b1);
    drain();

    write_reg(ptrc_pkg::REG_OFF_EN, '0);
    write_reg(ptrc_pkg::REG_MAP_ROT, 32'h00004000);
    queue_random(10);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      write_reg(ptrc_pkg::REG_ORIGIN_X, rand_pos());
      write_reg(ptrc_pkg::REG_ORIGIN_Y, rand_pos());
      write_reg(ptrc_pkg::REG_MAP_ROT, $urandom);
      write_reg(ptrc_pkg::REG_HEAD_OFF, $urandom);
      write_reg(ptrc_pkg::REG_LEVER_FWD, rand_pos());
      write_reg(ptrc_pkg::REG_LEVER_LAT, rand_pos());
      write_reg(ptrc_pkg::REG_OFF_EN, 32'(phase % 2));
      if (phase == 2) begin
        queue_random(20);
        hold_cycles = 400;
      end
      queue_random(180);
      drain();
    end

    done_sending = 1'b1;
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_residuals.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
